>>> hdl/pptx_pkg.sv
// Shared constants, codes, word types and queue helpers of the priority packet TX arbiter.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package pptx_pkg;

	localparam int NSRC         = 3;
	localparam int HEADER_BITS  = 64;
	localparam int HEADER_DEPTH = 4;
	localparam int BEAT_DEPTH   = 16;
	localparam int MAX_RESULTS  = 64;

	localparam int SRC_W     = 2;
	localparam int HFILL_W   = $clog2(HEADER_DEPTH + 1);
	localparam int BFILL_W   = $clog2(BEAT_DEPTH + 1);
	localparam int HPTR_W    = (HEADER_DEPTH > 1) ? $clog2(HEADER_DEPTH) : 1;
	localparam int BPTR_W    = $clog2(BEAT_DEPTH);
	localparam int HADDR_W   = $clog2(NSRC * HEADER_DEPTH);
	localparam int BADDR_W   = $clog2(NSRC * BEAT_DEPTH);
	localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

	localparam logic [7:0] TAIL_KEEP = 8'hff;

	localparam logic [2:0] CMD_RSP_HDR  = 3'd0;
	localparam logic [2:0] CMD_RT_HDR   = 3'd1;
	localparam logic [2:0] CMD_TX_HDR   = 3'd2;
	localparam logic [2:0] CMD_RSP_BEAT = 3'd3;
	localparam logic [2:0] CMD_RT_BEAT  = 3'd4;
	localparam logic [2:0] CMD_TX_BEAT  = 3'd5;

	localparam logic [SRC_W-1:0] SRC_RSP = 2'd0;
	localparam logic [SRC_W-1:0] SRC_RT  = 2'd1;
	localparam logic [SRC_W-1:0] SRC_TX  = 2'd2;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_RSP,
		MODE_RSP_TAIL,
		MODE_RT,
		MODE_TX
	} arb_mode_t;

	typedef enum logic [1:0] {
		KIND_HEADER,
		KIND_BEAT,
		KIND_TAIL
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [63:0] header_info;
		logic [63:0] beat_data;
		logic [7:0]  beat_keep;
		logic        beat_last;
	} in_word_t;

	typedef struct packed {
		logic             is_header;
		logic [SRC_W-1:0] source;
		logic [63:0]      out_header_info;
		logic [63:0]      out_data;
		logic [7:0]       out_keep;
		logic             out_last;
		logic             end_of_run;
	} out_word_t;

	typedef struct packed {
		logic        last;
		logic [7:0]  keep;
		logic [63:0] data;
	} beat_ent_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic enq;
		logic step;
		logic emit;
		logic eor;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic can_prog;
		logic out_free;
	} dp_stat_t;

	function automatic logic [HPTR_W-1:0] hptr_inc(input logic [HPTR_W-1:0] p);
		return (p == HPTR_W'(HEADER_DEPTH - 1)) ? '0 : p + HPTR_W'(1);
	endfunction

	function automatic logic [BPTR_W-1:0] bptr_inc(input logic [BPTR_W-1:0] p);
		return (p == BPTR_W'(BEAT_DEPTH - 1)) ? '0 : p + BPTR_W'(1);
	endfunction

	function automatic logic [HADDR_W-1:0] hdr_addr(input logic [SRC_W-1:0] s,
			input logic [HPTR_W-1:0] p);
		return HADDR_W'(s) * HADDR_W'(HEADER_DEPTH) + HADDR_W'(p);
	endfunction

	function automatic logic [BADDR_W-1:0] beat_addr(input logic [SRC_W-1:0] s,
			input logic [BPTR_W-1:0] p);
		return BADDR_W'(s) * BADDR_W'(BEAT_DEPTH) + BADDR_W'(p);
	endfunction

endpackage

`default_nettype wire

>>> hdl/pptx_in_if.sv
// Input channel of the arbiter: valid, ready and one input word.
// Depends on pptx_pkg for the word type.
`default_nettype none

interface pptx_in_if;
	logic               valid;
	logic               ready;
	pptx_pkg::in_word_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

>>> hdl/pptx_out_if.sv
// Output channel of the arbiter: valid, ready and one result word.
// Depends on pptx_pkg for the word type.
`default_nettype none

interface pptx_out_if;
	logic                valid;
	logic                ready;
	pptx_pkg::out_word_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

>>> hdl/pptx_ctrl.sv
// Controller of the arbiter: sequences accept, queue step and result load per input word.
// Depends on pptx_pkg for the state type and the command and status structs.
`default_nettype none

module pptx_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire pptx_pkg::dp_stat_t stat,
	output pptx_pkg::dp_cmd_t       cmd
);

	pptx_pkg::ctrl_state_t state_q, state_d;
	logic [pptx_pkg::RES_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pptx_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.enq) begin
				cnt_q <= '0;
			end else if (cmd.emit) begin
				cnt_q <= cnt_q + pptx_pkg::RES_CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			pptx_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.enq = 1'b1;
					state_d = pptx_pkg::ST_STEP;
				end
			end
			pptx_pkg::ST_STEP: begin
				if (stat.can_prog) begin
					cmd.step = 1'b1;
					state_d  = pptx_pkg::ST_EMIT;
				end else begin
					state_d = pptx_pkg::ST_IDLE;
				end
			end
			pptx_pkg::ST_EMIT: begin
				// Status already reflects the queues after this result's pop.
				cmd.eor = !stat.can_prog ||
					(cnt_q == pptx_pkg::RES_CNT_W'(pptx_pkg::MAX_RESULTS - 1));
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = cmd.eor ? pptx_pkg::ST_IDLE : pptx_pkg::ST_STEP;
				end
			end
			default: begin
				state_d = pptx_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/pptx_dp.sv
// Datapath of the arbiter: per-source header and beat queues, lock mode and output register.
// Depends on pptx_pkg; driven by pptx_ctrl through the command and status structs.
`default_nettype none

module pptx_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pptx_pkg::in_word_t in_word,
	input  wire pptx_pkg::dp_cmd_t  cmd,
	output pptx_pkg::dp_stat_t      stat,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output pptx_pkg::out_word_t     out_word
);

	logic [pptx_pkg::HEADER_BITS-1:0] hmem [pptx_pkg::NSRC*pptx_pkg::HEADER_DEPTH];
	pptx_pkg::beat_ent_t              bmem [pptx_pkg::NSRC*pptx_pkg::BEAT_DEPTH];

	logic [pptx_pkg::HFILL_W-1:0] hfill_q [pptx_pkg::NSRC];
	logic [pptx_pkg::BFILL_W-1:0] bfill_q [pptx_pkg::NSRC];
	logic [pptx_pkg::HPTR_W-1:0]  hrd_q   [pptx_pkg::NSRC];
	logic [pptx_pkg::HPTR_W-1:0]  hwr_q   [pptx_pkg::NSRC];
	logic [pptx_pkg::BPTR_W-1:0]  brd_q   [pptx_pkg::NSRC];
	logic [pptx_pkg::BPTR_W-1:0]  bwr_q   [pptx_pkg::NSRC];

	pptx_pkg::arb_mode_t mode_q, mode_eff, mode_step;
	logic                out_valid_q;
	pptx_pkg::out_word_t out_word_q, out_word_d;

	// Read stage: data fetched by a step, held until the result is loaded.
	logic                             pend_s1;
	pptx_pkg::kind_t                  kind_s1;
	logic [pptx_pkg::SRC_W-1:0]       src_s1;
	logic [pptx_pkg::HEADER_BITS-1:0] hdata_s1;
	pptx_pkg::beat_ent_t              bdata_s1;

	logic                       is_hdr_cmd, is_beat_cmd, hwe, bwe;
	logic [pptx_pkg::SRC_W-1:0] enq_src, step_src;
	pptx_pkg::kind_t            step_kind;

	// Enqueue decode; a word for a full queue is dropped.
	always_comb begin
		is_hdr_cmd  = (in_word.command == pptx_pkg::CMD_RSP_HDR) ||
			(in_word.command == pptx_pkg::CMD_RT_HDR) ||
			(in_word.command == pptx_pkg::CMD_TX_HDR);
		is_beat_cmd = (in_word.command == pptx_pkg::CMD_RSP_BEAT) ||
			(in_word.command == pptx_pkg::CMD_RT_BEAT) ||
			(in_word.command == pptx_pkg::CMD_TX_BEAT);
		enq_src     = is_hdr_cmd ? in_word.command[pptx_pkg::SRC_W-1:0] :
			pptx_pkg::SRC_W'(in_word.command - pptx_pkg::CMD_RSP_BEAT);
		hwe = cmd.enq && is_hdr_cmd &&
			(hfill_q[enq_src] != pptx_pkg::HFILL_W'(pptx_pkg::HEADER_DEPTH));
		bwe = cmd.enq && is_beat_cmd &&
			(bfill_q[enq_src] != pptx_pkg::BFILL_W'(pptx_pkg::BEAT_DEPTH));
	end

	// A loaded rt/tx beat with last set releases the lock.
	always_comb begin
		mode_eff = mode_q;
		if (pend_s1 && kind_s1 == pptx_pkg::KIND_BEAT && src_s1 != pptx_pkg::SRC_RSP &&
				bdata_s1.last) begin
			mode_eff = pptx_pkg::MODE_IDLE;
		end
	end

	always_comb begin
		step_src      = pptx_pkg::SRC_RSP;
		step_kind     = pptx_pkg::KIND_BEAT;
		mode_step     = mode_q;
		stat.can_prog = 1'b0;
		case (mode_eff)
			pptx_pkg::MODE_IDLE: begin
				step_kind = pptx_pkg::KIND_HEADER;
				if (hfill_q[0] != '0) begin
					step_src  = pptx_pkg::SRC_RSP;
					mode_step = pptx_pkg::MODE_RSP;
				end else if (hfill_q[1] != '0) begin
					step_src  = pptx_pkg::SRC_RT;
					mode_step = pptx_pkg::MODE_RT;
				end else begin
					step_src  = pptx_pkg::SRC_TX;
					mode_step = pptx_pkg::MODE_TX;
				end
				stat.can_prog = (hfill_q[0] != '0) || (hfill_q[1] != '0) ||
					(hfill_q[2] != '0);
			end
			pptx_pkg::MODE_RSP_TAIL: begin
				step_kind     = pptx_pkg::KIND_TAIL;
				mode_step     = pptx_pkg::MODE_IDLE;
				stat.can_prog = 1'b1;
			end
			pptx_pkg::MODE_RSP: begin
				step_src      = pptx_pkg::SRC_RSP;
				mode_step     = pptx_pkg::MODE_RSP_TAIL;
				stat.can_prog = bfill_q[0] != '0;
			end
			pptx_pkg::MODE_RT: begin
				step_src      = pptx_pkg::SRC_RT;
				stat.can_prog = bfill_q[1] != '0;
			end
			pptx_pkg::MODE_TX: begin
				step_src      = pptx_pkg::SRC_TX;
				stat.can_prog = bfill_q[2] != '0;
			end
			default: begin
				mode_step = pptx_pkg::MODE_IDLE;
			end
		endcase
		stat.out_free = !out_valid_q || out_ready;
	end

	// Queue memories: one write port for enqueue, one registered read port for the step.
	always_ff @(posedge clk) begin
		if (hwe) begin
			hmem[pptx_pkg::hdr_addr(enq_src, hwr_q[enq_src])] <=
				in_word.header_info[pptx_pkg::HEADER_BITS-1:0];
		end
		if (bwe) begin
			bmem[pptx_pkg::beat_addr(enq_src, bwr_q[enq_src])] <=
				'{last: in_word.beat_last, keep: in_word.beat_keep, data: in_word.beat_data};
		end
		if (cmd.step) begin
			hdata_s1 <= hmem[pptx_pkg::hdr_addr(step_src, hrd_q[step_src])];
			bdata_s1 <= bmem[pptx_pkg::beat_addr(step_src, brd_q[step_src])];
			src_s1   <= (step_kind == pptx_pkg::KIND_TAIL) ? pptx_pkg::SRC_RSP : step_src;
			kind_s1  <= step_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pptx_pkg::NSRC; i++) begin
				hfill_q[i] <= '0;
				bfill_q[i] <= '0;
				hrd_q[i]   <= '0;
				hwr_q[i]   <= '0;
				brd_q[i]   <= '0;
				bwr_q[i]   <= '0;
			end
			mode_q  <= pptx_pkg::MODE_IDLE;
			pend_s1 <= 1'b0;
		end else begin
			// Enqueue and step never fall in the same cycle.
			for (int i = 0; i < pptx_pkg::NSRC; i++) begin
				if (hwe && enq_src == pptx_pkg::SRC_W'(i)) begin
					hwr_q[i]   <= pptx_pkg::hptr_inc(hwr_q[i]);
					hfill_q[i] <= hfill_q[i] + pptx_pkg::HFILL_W'(1);
				end
				if (bwe && enq_src == pptx_pkg::SRC_W'(i)) begin
					bwr_q[i]   <= pptx_pkg::bptr_inc(bwr_q[i]);
					bfill_q[i] <= bfill_q[i] + pptx_pkg::BFILL_W'(1);
				end
				if (cmd.step && step_src == pptx_pkg::SRC_W'(i)) begin
					if (step_kind == pptx_pkg::KIND_HEADER) begin
						hrd_q[i]   <= pptx_pkg::hptr_inc(hrd_q[i]);
						hfill_q[i] <= hfill_q[i] - pptx_pkg::HFILL_W'(1);
					end else if (step_kind == pptx_pkg::KIND_BEAT) begin
						brd_q[i]   <= pptx_pkg::bptr_inc(brd_q[i]);
						bfill_q[i] <= bfill_q[i] - pptx_pkg::BFILL_W'(1);
					end
				end
			end
			if (cmd.step) begin
				mode_q  <= mode_step;
				pend_s1 <= 1'b1;
			end else if (cmd.emit) begin
				mode_q  <= mode_eff;
				pend_s1 <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result word built from the read stage; fields a kind does not use stay zero.
	always_comb begin
		out_word_d            = '0;
		out_word_d.source     = src_s1;
		out_word_d.end_of_run = cmd.eor;
		case (kind_s1)
			pptx_pkg::KIND_HEADER: begin
				out_word_d.is_header       = 1'b1;
				out_word_d.out_header_info = 64'(hdata_s1);
			end
			pptx_pkg::KIND_BEAT: begin
				out_word_d.out_data = bdata_s1.data;
				out_word_d.out_keep = bdata_s1.keep;
				out_word_d.out_last = bdata_s1.last;
			end
			pptx_pkg::KIND_TAIL: begin
				out_word_d.out_keep = pptx_pkg::TAIL_KEEP;
				out_word_d.out_last = 1'b1;
			end
			default: begin
				out_word_d.out_last = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_word_q <= out_word_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

`ifndef SYNTHESIS
	a_emit_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> pend_s1)
		else $error("result loaded without fetched queue data");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(hfill_q[0] <= pptx_pkg::HFILL_W'(pptx_pkg::HEADER_DEPTH)) &&
		(hfill_q[1] <= pptx_pkg::HFILL_W'(pptx_pkg::HEADER_DEPTH)) &&
		(hfill_q[2] <= pptx_pkg::HFILL_W'(pptx_pkg::HEADER_DEPTH)) &&
		(bfill_q[0] <= pptx_pkg::BFILL_W'(pptx_pkg::BEAT_DEPTH)) &&
		(bfill_q[1] <= pptx_pkg::BFILL_W'(pptx_pkg::BEAT_DEPTH)) &&
		(bfill_q[2] <= pptx_pkg::BFILL_W'(pptx_pkg::BEAT_DEPTH)))
		else $error("queue fill beyond depth");

	a_beat_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && step_kind == pptx_pkg::KIND_BEAT |-> bfill_q[step_src] != '0)
		else $error("beat popped from an empty queue");
`endif

endmodule

`default_nettype wire

>>> hdl/priority_packet_tx_arbiter.sv
// Top level of the priority packet TX arbiter: joins controller and datapath to the channels.
// Depends on pptx_pkg, pptx_in_if, pptx_out_if, pptx_ctrl and pptx_dp.
`default_nettype none

// Merges response, retransmit and transmit packet words onto one output link. Each input
// word is a header or a payload beat for one source and is queued per source (4 headers and
// 16 beats each); a word that meets a full queue is dropped. With no source locked, the
// queued header of highest priority (response, retransmit, transmit) is sent and the link
// locks to that source: a response sends one payload beat followed by a tail beat (data 0,
// keep 0xff, last set), the other sources send beats up to and including one with last set.
// After accepting a word the block sends every result the queues allow, up to 64, and marks
// the final one with end_of_run; a word that allows no progress yields no result. Each
// result takes a registered read of the queue memory and then a load of the output
// register, and that load waits while the output is stalled. The input is ready again as
// soon as the word's last result is in the output register, while that result still
// waits to be taken.
module priority_packet_tx_arbiter (
	input wire logic   clk,
	input wire logic   arst_n,
	pptx_in_if.sink    pkt_in,
	pptx_out_if.source pkt_out
);

	// Control handshake between the sequencer and the queue datapath.
	pptx_pkg::dp_cmd_t  cmd;
	pptx_pkg::dp_stat_t stat;

	pptx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pkt_in.valid),
		.in_ready (pkt_in.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath writes the accepted word into its queue and owns the output register.
	pptx_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (pkt_in.word),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (pkt_out.ready),
		.out_valid (pkt_out.valid),
		.out_word  (pkt_out.word)
	);

endmodule

`default_nettype wire
